/* rtl/core/rgb_hue_rotate_brightness_kept_defines.svh */
// Assertion macros shared by the hue rotation checker.
`ifndef RGB_HUE_ROTATE_BRIGHTNESS_KEPT_DEFINES_SVH
`define RGB_HUE_ROTATE_BRIGHTNESS_KEPT_DEFINES_SVH

// Check that an expression holds at every clock edge out of reset.
`define RHR_ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("hue rotation check failed");

// Check that a condition implies a consequence at the same edge.
`define RHR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hue rotation check failed");

`endif

/* rtl/core/rhr_pkg.sv */
// Shared types and constants of the hue rotation pipeline.
package rhr_pkg;

    localparam int DEG_FULL     = 360;
    localparam int DEG_SECTOR   = 60;
    localparam int CHAN_MAX     = 255;
    localparam int PCT_SCALE    = 100;

    // 360 * 92: makes any 16-bit signed angle non-negative
    localparam int ANGLE_BIAS   = 33120;
    localparam int MOD_RECIP    = 182;
    localparam int MOD_SHIFT    = 16;
    localparam int DIV100_RECIP = 5243;
    localparam int DIV100_SHIFT = 19;

    localparam int NUM_W = 17;
    localparam int DEN_W = 10;
    localparam int PCT_W = 9;

    typedef enum logic [1:0] {
        BR_RED   = 2'd0,
        BR_GREEN = 2'd1,
        BR_BLUE  = 2'd2
    } br_t;

    localparam logic [2:0] SEC_RED     = 3'd0;
    localparam logic [2:0] SEC_YELLOW  = 3'd1;
    localparam logic [2:0] SEC_GREEN   = 3'd2;
    localparam logic [2:0] SEC_CYAN    = 3'd3;
    localparam logic [2:0] SEC_BLUE    = 3'd4;

    typedef struct packed {
        logic            special;
        logic [23:0]     px;
        logic [2:0][7:0] chan;
    } pct_side_t;

endpackage

/* rtl/core/rhr_hue_div.sv */
// Pipelined restoring divider: (diff << FRAC_BITS) / den, one quotient bit per stage.
module rhr_hue_div
    import rhr_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           diff,
    input  logic [7:0]           den,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [FRAC_BITS:0]   quot,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int NS = FRAC_BITS + 1;

    logic                valid_reg [NS];
    logic [7:0]          rem_reg   [NS];
    logic [7:0]          den_reg   [NS];
    logic [FRAC_BITS:0]  quo_reg   [NS];
    logic [SIDE_W-1:0]   side_reg  [NS];

    logic       ge0;
    logic [7:0] rem0_next;

    // integer bit: diff never exceeds den
    assign ge0       = diff >= den;
    assign rem0_next = ge0 ? 8'(diff - den) : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= rem0_next;
        den_reg[0]  <= den;
        quo_reg[0]  <= (FRAC_BITS+1)'(ge0);
        side_reg[0] <= in_side;
    end

    generate
        for (genvar k = 1; k < NS; k++) begin : g_stage
            logic [8:0]         rem2;
            logic               ge;
            logic [7:0]         rem_next;
            logic [FRAC_BITS:0] quo_next;

            assign rem2     = {rem_reg[k-1], 1'b0};
            assign ge       = rem2 >= {1'b0, den_reg[k-1]};
            assign rem_next = ge ? 8'(rem2 - {1'b0, den_reg[k-1]}) : rem2[7:0];
            assign quo_next = {quo_reg[k-1][FRAC_BITS-1:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else
                    valid_reg[k] <= valid_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_reg[k-1];
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_reg[k-1];
            end
        end
    endgenerate

    assign out_valid = valid_reg[NS-1];
    assign quot      = quo_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

/* rtl/core/rhr_pct_div.sv */
// Pipelined long divider for the brightness percent, one quotient bit per stage.
module rhr_pct_div
    import rhr_pkg::*;
#(
    parameter int SIDE_W = 1
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    input  logic [SIDE_W-1:0]  in_side,
    output logic               out_valid,
    output logic [PCT_W-1:0]   pct,
    output logic [SIDE_W-1:0]  out_side
);

    localparam int TW = NUM_W + 2;

    logic               valid_reg [PCT_W];
    logic [NUM_W-1:0]   rem_reg   [PCT_W];
    logic [DEN_W-1:0]   den_reg   [PCT_W];
    logic [PCT_W-1:0]   quo_reg   [PCT_W];
    logic [SIDE_W-1:0]  side_reg  [PCT_W];

    generate
        for (genvar j = 0; j < PCT_W; j++) begin : g_stage
            localparam int K = PCT_W - 1 - j;
            logic               v_in;
            logic [NUM_W-1:0]   rem_in;
            logic [DEN_W-1:0]   den_in;
            logic [PCT_W-1:0]   quo_in;
            logic [SIDE_W-1:0]  side_in;
            logic [TW-1:0]      trial;
            logic               ge;
            logic [NUM_W-1:0]   rem_next;

            if (j == 0) begin : g_first
                assign v_in    = in_valid;
                assign rem_in  = num;
                assign den_in  = den;
                assign quo_in  = '0;
                assign side_in = in_side;
            end else begin : g_next
                assign v_in    = valid_reg[j-1];
                assign rem_in  = rem_reg[j-1];
                assign den_in  = den_reg[j-1];
                assign quo_in  = quo_reg[j-1];
                assign side_in = side_reg[j-1];
            end

            assign trial    = TW'(den_in) << K;
            assign ge       = TW'(rem_in) >= trial;
            assign rem_next = ge ? NUM_W'(TW'(rem_in) - trial) : rem_in;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[j] <= 1'b0;
                else
                    valid_reg[j] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[j]  <= rem_next;
                den_reg[j]  <= den_in;
                quo_reg[j]  <= {quo_in[PCT_W-2:0], ge};
                side_reg[j] <= side_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[PCT_W-1];
    assign pct       = quo_reg[PCT_W-1];
    assign out_side  = side_reg[PCT_W-1];

endmodule

/* rtl/core/rhr_scale.sv */
// Brightness scaling: channel * pct / 100 with clamp, and the output register.
module rhr_scale
    import rhr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [PCT_W-1:0] pct,
    input  pct_side_t        in_side,
    output logic             done,
    output logic [23:0]      rotated_pixel
);

    logic                  m_valid_reg;
    logic [2:0][NUM_W-1:0] m_prod_reg;
    pct_side_t             m_side_reg;

    logic                  q_valid_reg;
    logic [2:0][NUM_W-1:0] q_prod_reg;
    logic [2:0][9:0]       q_quo_reg;
    pct_side_t             q_side_reg;

    logic                  done_reg;
    logic [23:0]           rotated_pixel_reg;

    logic [2:0][NUM_W-1:0] prod_next;
    logic [2:0][9:0]       quo_next;
    logic [2:0][7:0]       chan_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = NUM_W'(in_side.chan[i]) * NUM_W'(pct);
        end
    end

    // reciprocal may overshoot by one; fixed in the last stage
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quo_next[i] = 10'((30'(m_prod_reg[i]) * 30'(DIV100_RECIP)) >> DIV100_SHIFT);
        end
    end

    always_comb
    begin
        logic [9:0] qfix;
        for (int i = 0; i < 3; i++)
        begin
            qfix = q_quo_reg[i];
            if ((NUM_W'(q_quo_reg[i]) * NUM_W'(PCT_SCALE)) > q_prod_reg[i])
                qfix = 10'(q_quo_reg[i] - 10'd1);
            chan_next[i] = (qfix > 10'(CHAN_MAX)) ? 8'(CHAN_MAX) : qfix[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            m_valid_reg <= in_valid;
            q_valid_reg <= m_valid_reg;
            done_reg    <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_prod_reg        <= prod_next;
        m_side_reg        <= in_side;
        q_prod_reg        <= m_prod_reg;
        q_quo_reg         <= quo_next;
        q_side_reg        <= m_side_reg;
        // grey and black pass through unchanged
        rotated_pixel_reg <= q_side_reg.special ? q_side_reg.px : chan_next;
    end

    assign done          = done_reg;
    assign rotated_pixel = rotated_pixel_reg;

endmodule

/* rtl/core/rgb_hue_rotate_brightness_kept.sv */
// Hue rotation of an RGB pixel with channel-sum compensation, top level.
//
// Usage:
//   Drive pixel (red 23..16, green 15..8, blue 7..0) and hue_shift (signed
//   degrees) and raise start; the item is taken at that clock edge.
//   busy is always low: a new item may be taken in every cycle.
//   The result is on rotated_pixel for one cycle with done high.
//   Throughput is one item per clock; the two restoring dividers (hue
//   fraction, FRAC_BITS + 1 stages, and brightness percent, 9 stages)
//   set the depth, one quotient bit per stage.
//   The receiver cannot stall the pipeline; results flow out as they come.
//   Reset clears all valid bits, so nothing leaves the block until new
//   items are taken; items in flight at reset are dropped.
//   Grey and black pixels come out unchanged.
module rgb_hue_rotate_brightness_kept
    import rhr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [23:0]        pixel,
    input  logic signed [15:0] hue_shift,
    output logic               done,
    output logic [23:0]        rotated_pixel
);

    localparam int HW = FRAC_BITS + 3;
    localparam int EW = FRAC_BITS + 8;
    localparam logic [HW-1:0] TWO_H  = HW'(2) << FRAC_BITS;
    localparam logic [HW-1:0] FOUR_H = HW'(4) << FRAC_BITS;
    localparam logic [HW-1:0] FULL_H = HW'(6) << FRAC_BITS;

    typedef struct packed {
        br_t           br;
        logic          neg;
        logic [7:0]    d;
        logic [7:0]    mn;
        logic [7:0]    mx;
        logic [23:0]   px;
        logic [9:0]    s1sum;
        logic [HW-1:0] ang_h;
    } hue_side_t;

    // fraction of one sector for each leftover degree count
    logic [FRAC_BITS-1:0] frac_tab [64];

    generate
        for (genvar i = 0; i < 64; i++) begin : g_tab
            localparam longint V = (i < DEG_SECTOR) ?
                                   ((longint'(i) << FRAC_BITS) / DEG_SECTOR) : 0;
            assign frac_tab[i] = FRAC_BITS'(V);
        end
    endgenerate

    assign busy = 1'b0;

    // ---- stage 1: input register
    logic               s1_valid_reg;
    logic [23:0]        s1_px_reg;
    logic signed [15:0] s1_ang_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_px_reg  <= pixel;
        s1_ang_reg <= hue_shift;
    end

    // ---- stage 2: max, min, branch, angle bias and reciprocal product
    logic [7:0]         c_r, c_g, c_b, c_mx, c_mn, c_hi, c_lo, c_t;
    br_t                c_br;
    logic signed [17:0] c_ang_ext;
    logic [16:0]        c_u;
    logic [24:0]        c_qe_prod;

    always_comb
    begin
        c_r  = s1_px_reg[23:16];
        c_g  = s1_px_reg[15:8];
        c_b  = s1_px_reg[7:0];
        c_t  = (c_r > c_g) ? c_r : c_g;
        c_mx = (c_t > c_b) ? c_t : c_b;
        c_t  = (c_r < c_g) ? c_r : c_g;
        c_mn = (c_t < c_b) ? c_t : c_b;
        if (c_r == c_mx)
        begin
            c_br = BR_RED;
            c_hi = c_g;
            c_lo = c_b;
        end
        else if (c_g == c_mx)
        begin
            c_br = BR_GREEN;
            c_hi = c_b;
            c_lo = c_r;
        end
        else
        begin
            c_br = BR_BLUE;
            c_hi = c_r;
            c_lo = c_g;
        end
        c_ang_ext = 18'(s1_ang_reg);
        c_u       = 17'(c_ang_ext + 18'(ANGLE_BIAS));
        c_qe_prod = 25'(c_u) * 25'(MOD_RECIP);
    end

    logic        s2_valid_reg;
    logic [23:0] s2_px_reg;
    br_t         s2_br_reg;
    logic [7:0]  s2_hi_reg, s2_lo_reg, s2_mx_reg, s2_mn_reg, s2_qe_reg;
    logic [16:0] s2_u_reg;
    logic [9:0]  s2_s1sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_px_reg    <= s1_px_reg;
        s2_br_reg    <= c_br;
        s2_hi_reg    <= c_hi;
        s2_lo_reg    <= c_lo;
        s2_mx_reg    <= c_mx;
        s2_mn_reg    <= c_mn;
        s2_qe_reg    <= 8'(c_qe_prod >> MOD_SHIFT);
        s2_u_reg     <= c_u;
        s2_s1sum_reg <= 10'(c_r) + 10'(c_g) + 10'(c_b);
    end

    // ---- stage 3: hue difference, angle modulo 360
    logic        c3_neg;
    logic [7:0]  c3_diff;
    logic [16:0] c3_p360;
    logic [9:0]  c3_araw;
    logic [8:0]  c3_a;

    always_comb
    begin
        c3_neg  = s2_hi_reg < s2_lo_reg;
        c3_diff = c3_neg ? 8'(s2_lo_reg - s2_hi_reg) : 8'(s2_hi_reg - s2_lo_reg);
        c3_p360 = 17'(s2_qe_reg) * 17'(DEG_FULL);
        c3_araw = 10'(s2_u_reg - c3_p360);
        // quotient estimate may be one short
        c3_a    = (c3_araw >= 10'(DEG_FULL)) ? 9'(c3_araw - 10'(DEG_FULL)) : c3_araw[8:0];
    end

    logic        s3_valid_reg;
    logic [23:0] s3_px_reg;
    br_t         s3_br_reg;
    logic        s3_neg_reg;
    logic [7:0]  s3_diff_reg, s3_d_reg, s3_mx_reg, s3_mn_reg;
    logic [9:0]  s3_s1sum_reg;
    logic [8:0]  s3_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_px_reg    <= s2_px_reg;
        s3_br_reg    <= s2_br_reg;
        s3_neg_reg   <= c3_neg;
        s3_diff_reg  <= c3_diff;
        s3_d_reg     <= 8'(s2_mx_reg - s2_mn_reg);
        s3_mx_reg    <= s2_mx_reg;
        s3_mn_reg    <= s2_mn_reg;
        s3_s1sum_reg <= s2_s1sum_reg;
        s3_a_reg     <= c3_a;
    end

    // ---- stage 4: angle to sector and fraction
    logic [2:0] c4_sec;
    logic [5:0] c4_r60;
    hue_side_t  c4_side;

    always_comb
    begin
        c4_sec = 3'(s3_a_reg >= 9'(DEG_SECTOR))     + 3'(s3_a_reg >= 9'(2 * DEG_SECTOR))
               + 3'(s3_a_reg >= 9'(3 * DEG_SECTOR)) + 3'(s3_a_reg >= 9'(4 * DEG_SECTOR))
               + 3'(s3_a_reg >= 9'(5 * DEG_SECTOR));
        c4_r60 = 6'(s3_a_reg - 9'(c4_sec) * 9'(DEG_SECTOR));
        c4_side.br    = s3_br_reg;
        c4_side.neg   = s3_neg_reg;
        c4_side.d     = s3_d_reg;
        c4_side.mn    = s3_mn_reg;
        c4_side.mx    = s3_mx_reg;
        c4_side.px    = s3_px_reg;
        c4_side.s1sum = s3_s1sum_reg;
        c4_side.ang_h = {c4_sec, frac_tab[c4_r60]};
    end

    logic       s4_valid_reg;
    logic [7:0] s4_diff_reg, s4_d_reg;
    hue_side_t  s4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_diff_reg <= s3_diff_reg;
        s4_d_reg    <= s3_d_reg;
        s4_side_reg <= c4_side;
    end

    // ---- hue fraction divider
    logic               hd_valid;
    logic [FRAC_BITS:0] hd_quot;
    hue_side_t          hd_side;

    rhr_hue_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(hue_side_t))
    ) u_hue_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .diff      (s4_diff_reg),
        .den       (s4_d_reg),
        .in_side   (s4_side_reg),
        .out_valid (hd_valid),
        .quot      (hd_quot),
        .out_side  (hd_side)
    );

    // ---- stage 5: hue position from branch
    logic [HW-1:0] c5_q, c5_base, c5_h;

    always_comb
    begin
        c5_q = HW'(hd_quot);
        case (hd_side.br)
            BR_RED:   c5_base = hd_side.neg ? HW'(FULL_H - c5_q) : c5_q;
            BR_GREEN: c5_base = hd_side.neg ? HW'(TWO_H - c5_q) : HW'(TWO_H + c5_q);
            default:  c5_base = hd_side.neg ? HW'(FOUR_H - c5_q) : HW'(FOUR_H + c5_q);
        endcase
        c5_h = (c5_base >= FULL_H) ? HW'(c5_base - FULL_H) : c5_base;
    end

    logic          s5_valid_reg;
    logic [HW-1:0] s5_h_reg, s5_ang_reg;
    logic [7:0]    s5_d_reg, s5_mn_reg, s5_mx_reg;
    logic [23:0]   s5_px_reg;
    logic [9:0]    s5_s1sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else
            s5_valid_reg <= hd_valid;
    end

    always_ff @(posedge clk)
    begin
        s5_h_reg     <= c5_h;
        s5_ang_reg   <= hd_side.ang_h;
        s5_d_reg     <= hd_side.d;
        s5_mn_reg    <= hd_side.mn;
        s5_mx_reg    <= hd_side.mx;
        s5_px_reg    <= hd_side.px;
        s5_s1sum_reg <= hd_side.s1sum;
    end

    // ---- stage 6: add rotation with wrap
    logic [HW:0]   c6_sum;
    logic [HW-1:0] c6_h;

    always_comb
    begin
        c6_sum = {1'b0, s5_h_reg} + {1'b0, s5_ang_reg};
        c6_h   = (c6_sum >= {1'b0, FULL_H}) ? HW'(c6_sum - {1'b0, FULL_H}) : HW'(c6_sum);
    end

    logic          s6_valid_reg;
    logic [HW-1:0] s6_h_reg;
    logic [7:0]    s6_d_reg, s6_mn_reg, s6_mx_reg;
    logic [23:0]   s6_px_reg;
    logic [9:0]    s6_s1sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s6_h_reg     <= c6_h;
        s6_d_reg     <= s5_d_reg;
        s6_mn_reg    <= s5_mn_reg;
        s6_mx_reg    <= s5_mx_reg;
        s6_px_reg    <= s5_px_reg;
        s6_s1sum_reg <= s5_s1sum_reg;
    end

    // ---- stage 7: ramp e = d * fraction
    logic [EW-1:0] c7_ef;

    assign c7_ef = EW'(s6_d_reg) * EW'(s6_h_reg[FRAC_BITS-1:0]);

    logic        s7_valid_reg;
    logic [2:0]  s7_sec_reg;
    logic [7:0]  s7_e_reg, s7_mn_reg, s7_mx_reg;
    logic [23:0] s7_px_reg;
    logic [9:0]  s7_s1sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else
            s7_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s7_sec_reg   <= s6_h_reg[HW-1:FRAC_BITS];
        s7_e_reg     <= c7_ef[EW-1:FRAC_BITS];
        s7_mn_reg    <= s6_mn_reg;
        s7_mx_reg    <= s6_mx_reg;
        s7_px_reg    <= s6_px_reg;
        s7_s1sum_reg <= s6_s1sum_reg;
    end

    // ---- stage 8: rebuild channels, sums for the percent
    logic [7:0] c8_up, c8_down;
    pct_side_t  c8_side;

    always_comb
    begin
        c8_up   = 8'(s7_mn_reg + s7_e_reg);
        c8_down = 8'(s7_mx_reg - s7_e_reg);
        c8_side.special = s7_mx_reg == s7_mn_reg;
        c8_side.px      = s7_px_reg;
        case (s7_sec_reg)
            SEC_RED:    c8_side.chan = {s7_mx_reg, c8_up,     s7_mn_reg};
            SEC_YELLOW: c8_side.chan = {c8_down,   s7_mx_reg, s7_mn_reg};
            SEC_GREEN:  c8_side.chan = {s7_mn_reg, s7_mx_reg, c8_up};
            SEC_CYAN:   c8_side.chan = {s7_mn_reg, c8_down,   s7_mx_reg};
            SEC_BLUE:   c8_side.chan = {c8_up,     s7_mn_reg, s7_mx_reg};
            default:    c8_side.chan = {s7_mx_reg, s7_mn_reg, c8_down};
        endcase
    end

    logic             s8_valid_reg;
    logic [NUM_W-1:0] s8_num_reg;
    logic [DEN_W-1:0] s8_den_reg;
    pct_side_t        s8_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_valid_reg <= 1'b0;
        else
            s8_valid_reg <= s7_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s8_num_reg  <= NUM_W'(s7_s1sum_reg) * NUM_W'(PCT_SCALE);
        s8_den_reg  <= DEN_W'(c8_side.chan[2]) + DEN_W'(c8_side.chan[1])
                     + DEN_W'(c8_side.chan[0]);
        s8_side_reg <= c8_side;
    end

    // ---- brightness percent divider and scaling
    logic             pd_valid;
    logic [PCT_W-1:0] pd_pct;
    pct_side_t        pd_side;

    rhr_pct_div #(
        .SIDE_W    ($bits(pct_side_t))
    ) u_pct_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s8_valid_reg),
        .num       (s8_num_reg),
        .den       (s8_den_reg),
        .in_side   (s8_side_reg),
        .out_valid (pd_valid),
        .pct       (pd_pct),
        .out_side  (pd_side)
    );

    rhr_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (pd_valid),
        .pct           (pd_pct),
        .in_side       (pd_side),
        .done          (done),
        .rotated_pixel (rotated_pixel)
    );

endmodule

/* rtl/core/rhr_checker.sv */
// Port-level checker for the hue rotation block, bound to the top level.
`include "rgb_hue_rotate_brightness_kept_defines.svh"

module rhr_checker #(
    parameter int FRAC_BITS = 16
)(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [23:0]        pixel,
    input logic signed [15:0] hue_shift,
    input logic               done,
    input logic [23:0]        rotated_pixel
);

    localparam int LAT = FRAC_BITS + 21;

    `RHR_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

    `RHR_ASSERT_IMPL(a_done_has_item, clk, rst_n, done, $past(start, LAT))

    `RHR_ASSERT_IMPL(a_grey_kept, clk, rst_n, done && $past(pixel[23:16] == pixel[15:8] && pixel[15:8] == pixel[7:0], LAT), rotated_pixel == $past(pixel, LAT))

endmodule

bind rgb_hue_rotate_brightness_kept rhr_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_rhr_checker (.*);

/* verif/hue_rotate_checker.sv */
// Checker for the hue rotation block: predicts each result and compares it.
module hue_rotate_checker
    import rhr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [23:0]        pixel,
    input  logic signed [15:0] hue_shift,
    input  logic               done,
    input  logic [23:0]        rotated_pixel,
    output int                 fail_count,
    output int                 pending
);

    logic [23:0] rotated_q[$];

    function automatic logic [7:0] rescale(longint unsigned c, longint unsigned pct);
        longint unsigned v;
        v = (c * pct) / PCT_SCALE;
        return (v > CHAN_MAX) ? 8'(CHAN_MAX) : 8'(v);
    endfunction

    function automatic logic [23:0] rotate_pixel(logic [23:0] px, logic signed [15:0] sh);
        longint unsigned one, whole, h, q, f, e, r, g, b, mx, mn, d;
        longint unsigned nr, ng, nb, s1, s2, pct, a;
        int ang;
        one = 64'd1 << FRAC_BITS;
        whole = 6 * one;
        r = px[23:16];
        g = px[15:8];
        b = px[7:0];
        ang = int'(sh) % DEG_FULL;
        if (ang < 0)
            ang += DEG_FULL;
        a = ang;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        if (mx == 0)
            return 24'd0;
        if (mx == mn)
            return px;
        d = mx - mn;
        if (r == mx)
        begin
            q = (((g > b) ? g - b : b - g) << FRAC_BITS) / d;
            h = (g < b) ? whole - q : q;
        end
        else if (g == mx)
        begin
            q = (((b > r) ? b - r : r - b) << FRAC_BITS) / d;
            h = (b < r) ? 2 * one - q : 2 * one + q;
        end
        else
        begin
            q = (((r > g) ? r - g : g - r) << FRAC_BITS) / d;
            h = (r < g) ? 4 * one - q : 4 * one + q;
        end
        if (h >= whole)
            h -= whole;
        h += (a / DEG_SECTOR) * one + ((a % DEG_SECTOR) * one) / DEG_SECTOR;
        if (h >= whole)
            h -= whole;
        f = h & (one - 1);
        e = (d * f) >> FRAC_BITS;
        case (h >> FRAC_BITS)
            SEC_RED:    begin nr = mx;     ng = mn + e; nb = mn;     end
            SEC_YELLOW: begin nr = mx - e; ng = mx;     nb = mn;     end
            SEC_GREEN:  begin nr = mn;     ng = mx;     nb = mn + e; end
            SEC_CYAN:   begin nr = mn;     ng = mx - e; nb = mx;     end
            SEC_BLUE:   begin nr = mn + e; ng = mn;     nb = mx;     end
            default:    begin nr = mx;     ng = mn;     nb = mx - e; end
        endcase
        s1 = r + g + b;
        s2 = nr + ng + nb;
        if (s2 == 0)
            s2 = 1;
        pct = (PCT_SCALE * s1) / s2;
        return {rescale(nr, pct), rescale(ng, pct), rescale(nb, pct)};
    endfunction

    assign pending = rotated_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [23:0] want;
        if (!rst_n)
        begin
            fail_count <= 0;
            rotated_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (rotated_q.size() == 0)
                begin
                    $error("rotated_pixel: none expected, actual %06h", rotated_pixel);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = rotated_q.pop_front();
                    if (want !== rotated_pixel)
                    begin
                        $error("rotated_pixel: expected %06h, actual %06h", want, rotated_pixel);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                rotated_q.push_back(rotate_pixel(pixel, hue_shift));
        end
    end

endmodule

/* verif/testbench.sv */
// Stimulus and verdict for the hue rotation block.
module testbench;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [23:0]        pixel = '0;
    logic signed [15:0] hue_shift = '0;
    logic               done;
    logic [23:0]        rotated_pixel;
    int                 fail_count;
    int                 pending;
    int                 quiet_cycles = 0;
    int                 idle_pct = 0;
    logic               timed_out = 1'b0;

    localparam int LATENCY = 37;
    localparam int QUIET_LIMIT = 2000;

    always #1 clk = ~clk;

    rgb_hue_rotate_brightness_kept dut (.*);
    hue_rotate_checker checker_i (.*);

    // Count cycles with no traffic.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(logic [23:0] px, logic [15:0] sh);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel <= px;
        hue_shift <= sh;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [23:0] random_pixel();
        logic [7:0] lo, hi;
        lo = 8'($urandom);
        hi = 8'($urandom);
        case ($urandom_range(5))
            0: return {3{lo}};
            1: return {lo, lo, hi};
            2: return {hi, lo, lo};
            3: return {lo, hi, hi};
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_angle();
        case ($urandom_range(3))
            0: return 16'($urandom_range(719)) - 16'd360;
            1: return 16'($urandom_range(6)) * 16'd60;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [23:0] px_set[$];
        logic [15:0] ang_set[$];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        px_set = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00,
                   24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h123456,
                   24'hFE01A0, 24'h0102FF};
        ang_set = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd1, 16'sd360, 16'sd359,
                    16'sd60, -16'sd360, 16'sd120, 16'sd180, 16'sd240, 16'sd300};
        foreach (px_set[i])
            send_item(px_set[i], ang_set[i]);
        send_item(24'h204060, 16'h7FFF);
        send_item(24'hDFBF9F, 16'h8000);
        // Let the pipeline drain before random traffic.
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 0) ? 0 : (phase == 1) ? 54 : (phase == 2) ? 0 : 9;
            repeat (300)
                send_item(random_pixel(), random_angle());
        end
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
